FILE: rtl/rcf_pkg.sv
package rcf_pkg;

   // field and state widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int STATE_W  = 24;
   localparam int FRAC_W   = STATE_W - SAMPLE_W;

   // multiplier operand widths: coefficient up to 2^COEF_W, operand two bits over state
   localparam int C_W     = COEF_W + 1;
   localparam int V_W     = STATE_W + 2;
   localparam int P_W     = V_W + C_W;
   localparam int PROD_W  = P_W - COEF_W;
   localparam int SUM_W   = STATE_W + 3;
   localparam int CNT_W   = $clog2(C_W + 1);

   // configuration port
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_COEF = 1'b1;

   localparam logic [1:0] MODE_LP   = 2'd0;
   localparam logic [1:0] MODE_HP   = 2'd1;
   localparam logic [1:0] MODE_BP   = 2'd2;
   localparam logic [1:0] MODE_PASS = 2'd3;

   localparam logic [1:0]        MODE_RESET = MODE_LP;
   localparam logic [COEF_W-1:0] COEF_RESET = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic [C_W-1:0]    COEF_ONE   = {1'b1, {COEF_W{1'b0}}};

   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [STATE_W-1:0]  ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic [STATE_W-1:0]  ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP1,
      ST_MUL1,
      ST_PREP2,
      ST_MUL2,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             start;
      logic [C_W-1:0]   coef;
      logic [V_W-1:0]   value;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic               ovf;
      logic [STATE_W-1:0] val;
   } sat_st_type;

   typedef struct packed {
      logic                ovf;
      logic [SAMPLE_W-1:0] val;
   } sat_smp_type;

   // clamp a grown sum to the state width
   function automatic sat_st_type sat_state(input logic [SUM_W-1:0] v);
      sat_st_type r;
      r.ovf = (v[SUM_W-1:STATE_W-1] != {(SUM_W-STATE_W+1){v[SUM_W-1]}});
      r.val = r.ovf ? (v[SUM_W-1] ? ST_MIN : ST_MAX) : v[STATE_W-1:0];
      return r;
   endfunction

   // clamp a value one bit wider than a sample
   function automatic sat_smp_type sat_sample(input logic [SAMPLE_W:0] v);
      sat_smp_type r;
      r.ovf = (v[SAMPLE_W] != v[SAMPLE_W-1]);
      r.val = r.ovf ? (v[SAMPLE_W] ? SMP_MIN : SMP_MAX) : v[SAMPLE_W-1:0];
      return r;
   endfunction

endpackage

FILE: rtl/rcf_if.sv
interface rcf_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic signed [rcf_pkg::SAMPLE_W-1:0] sample_in;

   modport source (output valid, output cmd, output sample_in, input ready);
   modport sink   (input valid, input cmd, input sample_in, output ready);
endinterface

interface rcf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rcf_pkg::SAMPLE_W-1:0] sample_out;
   logic                                clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: rtl/rcf_mul.sv
// Bit-serial coefficient multiplier: one coefficient bit per cycle, MSB first,
// then round the product by 2^COEF_W with halves toward +infinity.
module rcf_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rcf_pkg::mul_req_type mul_req,
   output rcf_pkg::mul_rsp_type mul_rsp
);
   import rcf_pkg::*;

   logic                    busy_ff, busy_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [C_W-1:0]          coef_sh_ff, coef_sh_in;
   logic signed [V_W-1:0]   val_ff, val_in;
   logic signed [P_W-1:0]   acc_ff, acc_in;
   logic                    done_ff, done_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [P_W-1:0]   rnd;

   assign rnd = acc_ff + P_W'(signed'({1'b0, 1'b1, {(COEF_W-1){1'b0}}}));

   always_comb begin
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      coef_sh_in = coef_sh_ff;
      val_in     = val_ff;
      acc_in     = acc_ff;
      done_in    = 1'b0;
      prod_in    = prod_ff;
      // load operands
      if (mul_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(C_W);
         coef_sh_in = mul_req.coef;
         val_in     = $signed(mul_req.value);
         acc_in     = '0;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            // shift and add one coefficient bit
            acc_in     = (acc_ff <<< 1) + (coef_sh_ff[C_W-1] ? P_W'(val_ff) : '0);
            coef_sh_in = coef_sh_ff << 1;
            cnt_in     = cnt_ff - 1'b1;
         end else begin
            // round and hand back
            prod_in = rnd[P_W-1:COEF_W];
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      coef_sh_ff <= coef_sh_in;
      val_ff     <= val_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = prod_ff;

endmodule

FILE: rtl/one_pole_rc_filter_lp_hp_bp_unit.sv
// First-order RC filter (lowpass, highpass, bandpass) on signed 16-bit samples.
// Each request beat carries a command and a sample; each produces exactly one
// response beat. In lowpass or highpass mode a filter beat steps through the
// prepare, multiply, round and finish states; bandpass adds a second prepare
// and multiply. Clear and the unused mode 3 go straight to finish. The
// bit-serial multiplier walks the 17-bit coefficient one bit per cycle
// and is used once per beat (twice in bandpass). One beat is in the filter at
// a time; a finished response waits in the output register while the next
// request is taken. Write filter_mode at byte address 0 and smoothing_coef at
// address 4 only while no beat is outstanding; each mode keeps its own state,
// zeroed by a clear beat.
module one_pole_rc_filter_lp_hp_bp_unit (
   input  logic                        clock,
   input  logic                        reset,
   rcf_req_if.sink                     req_bus,
   rcf_rsp_if.source                   rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rcf_pkg::ADDR_W-1:0]  paddr,
   input  logic [rcf_pkg::DATA_W-1:0]  pwdata,
   output logic [rcf_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import rcf_pkg::*;

   state_type                   state_ff, state_in;
   logic [1:0]                  mode_ff, mode_in;
   logic [COEF_W-1:0]           coef_ff, coef_in;
   logic signed [SAMPLE_W-1:0]  x_ff, x_in;
   logic signed [STATE_W-1:0]   lp_ff, lp_in;
   logic signed [STATE_W-1:0]   hp_ff, hp_in;
   logic signed [SAMPLE_W-1:0]  hpi_ff, hpi_in;
   logic signed [STATE_W-1:0]   bh_ff, bh_in;
   logic signed [SAMPLE_W-1:0]  bpi_ff, bpi_in;
   logic signed [STATE_W-1:0]   bl_ff, bl_in;
   logic signed [STATE_W-1:0]   y_ff, y_in;
   logic                        clip_ff, clip_in;
   logic [SAMPLE_W-1:0]         res_ff, res_in;
   logic                        res_clip_ff, res_clip_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]         rsp_sample_ff, rsp_sample_in;
   logic                        rsp_clip_ff, rsp_clip_in;

   mul_req_type                 mul_req;
   mul_rsp_type                 mul_rsp;

   logic                        accept;
   logic                        cfg_wr;
   logic                        reg_idx;
   logic [C_W-1:0]              coef_b;
   logic [C_W-1:0]              coef_a;
   logic signed [STATE_W-1:0]   xs;
   logic signed [STATE_W-1:0]   xp_hp;
   logic signed [STATE_W-1:0]   xp_bp;
   logic signed [SUM_W-1:0]     prod_s;
   logic signed [SUM_W-1:0]     sum;
   logic signed [STATE_W:0]     rnd;
   sat_st_type                  sat_s;
   sat_smp_type                 sat_o;

   rcf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // handshakes and operand views
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign pready        = 1'b1;
   assign cfg_wr        = psel && penable && pwrite && pready;
   assign reg_idx       = paddr[ADDR_W-1];
   assign prdata        = (reg_idx == REG_MODE) ? DATA_W'(mode_ff) : DATA_W'(coef_ff);
   assign coef_b        = {1'b0, coef_ff};
   assign coef_a        = COEF_ONE - coef_b;
   assign xs            = {x_ff, {FRAC_W{1'b0}}};
   assign xp_hp         = {hpi_ff, {FRAC_W{1'b0}}};
   assign xp_bp         = {bpi_ff, {FRAC_W{1'b0}}};
   assign prod_s        = $signed(mul_rsp.prod);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.cmd == CMD_CLEAR || mode_ff == MODE_PASS) state_in = ST_FINISH;
               else state_in = ST_PREP1;
            end
         end
         ST_PREP1: state_in = ST_MUL1;
         ST_MUL1: begin
            if (mul_rsp.done) state_in = (mode_ff == MODE_BP) ? ST_PREP2 : ST_ROUND;
         end
         ST_PREP2: state_in = ST_MUL2;
         ST_MUL2: begin
            if (mul_rsp.done) state_in = ST_ROUND;
         end
         ST_ROUND: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in       = mode_ff;
      coef_in       = coef_ff;
      x_in          = x_ff;
      lp_in         = lp_ff;
      hp_in         = hp_ff;
      hpi_in        = hpi_ff;
      bh_in         = bh_ff;
      bpi_in        = bpi_ff;
      bl_in         = bl_ff;
      y_in          = y_ff;
      clip_in       = clip_ff;
      res_in        = res_ff;
      res_clip_in   = res_clip_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      mul_req.start = 1'b0;
      mul_req.coef  = coef_b;
      mul_req.value = '0;
      sum           = '0;
      sat_s         = sat_state(sum);
      rnd           = '0;
      sat_o         = sat_sample('0);

      // register writes
      if (cfg_wr) begin
         if (reg_idx == REG_MODE) mode_in = pwdata[1:0];
         else coef_in = pwdata[COEF_W-1:0];
      end

      // drop the response once taken
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in    = req_bus.sample_in;
               clip_in = 1'b0;
               if (req_bus.cmd == CMD_CLEAR) begin
                  lp_in       = '0;
                  hp_in       = '0;
                  hpi_in      = '0;
                  bh_in       = '0;
                  bpi_in      = '0;
                  bl_in       = '0;
                  res_in      = '0;
                  res_clip_in = 1'b0;
               end else if (mode_ff == MODE_PASS) begin
                  res_in      = req_bus.sample_in;
                  res_clip_in = 1'b0;
               end
            end
         end
         ST_PREP1: begin
            // first product of the beat
            mul_req.start = 1'b1;
            unique case (mode_ff)
               MODE_HP: begin
                  mul_req.coef  = coef_a;
                  mul_req.value = V_W'(hp_ff) + V_W'(xs) - V_W'(xp_hp);
               end
               MODE_BP: begin
                  mul_req.coef  = coef_a;
                  mul_req.value = V_W'(bh_ff);
               end
               default: begin
                  mul_req.coef  = coef_b;
                  mul_req.value = V_W'(xs) - V_W'(lp_ff);
               end
            endcase
         end
         ST_MUL1: begin
            if (mul_rsp.done) begin
               unique case (mode_ff)
                  MODE_HP: sum = prod_s;
                  MODE_BP: sum = SUM_W'(xs) - SUM_W'(xp_bp) + prod_s;
                  default: sum = SUM_W'(lp_ff) + prod_s;
               endcase
               sat_s   = sat_state(sum);
               clip_in = clip_ff | sat_s.ovf;
               y_in    = sat_s.val;
               unique case (mode_ff)
                  MODE_HP: begin
                     hp_in  = sat_s.val;
                     hpi_in = x_ff;
                  end
                  MODE_BP: begin
                     bh_in  = sat_s.val;
                     bpi_in = x_ff;
                  end
                  default: lp_in = sat_s.val;
               endcase
            end
         end
         ST_PREP2: begin
            // bandpass lowpass stage
            mul_req.start = 1'b1;
            mul_req.coef  = coef_b;
            mul_req.value = V_W'(bh_ff) - V_W'(bl_ff);
         end
         ST_MUL2: begin
            if (mul_rsp.done) begin
               sum     = SUM_W'(bl_ff) + prod_s;
               sat_s   = sat_state(sum);
               clip_in = clip_ff | sat_s.ovf;
               bl_in   = sat_s.val;
               y_in    = sat_s.val;
            end
         end
         ST_ROUND: begin
            // scale state back to a sample, round half up, clamp
            rnd         = (STATE_W+1)'(y_ff) + (STATE_W+1)'(1 << (FRAC_W - 1));
            sat_o       = sat_sample(rnd[STATE_W:FRAC_W]);
            res_in      = sat_o.val;
            res_clip_in = clip_ff | sat_o.ovf;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_ff;
               rsp_clip_in   = res_clip_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         coef_ff      <= COEF_RESET;
         lp_ff        <= '0;
         hp_ff        <= '0;
         hpi_ff       <= '0;
         bh_ff        <= '0;
         bpi_ff       <= '0;
         bl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         coef_ff      <= coef_in;
         lp_ff        <= lp_in;
         hp_ff        <= hp_in;
         hpi_ff       <= hpi_in;
         bh_ff        <= bh_in;
         bpi_ff       <= bpi_in;
         bl_ff        <= bl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      clip_ff       <= clip_in;
      res_ff        <= res_in;
      res_clip_ff   <= res_clip_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_sample_ff;
   assign rsp_bus.clipped    = rsp_clip_ff;

   // a clear beat leaves every filter state at zero
   assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.cmd == CMD_CLEAR |=>
         lp_ff == '0 && hp_ff == '0 && hpi_ff == '0 &&
         bh_ff == '0 && bpi_ff == '0 && bl_ff == '0)
      else $error("filter state not zeroed by clear");

   // the multiplier reports only while a product is awaited
   assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == ST_MUL1 || state_ff == ST_MUL2)
      else $error("multiplier done outside a multiply phase");

   // a response appears only out of the finish phase
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish");

endmodule

FILE: sim/rcf_filter_checker.sv
`timescale 1ns / 100ps

module rcf_filter_checker (
   input  logic                       clock,
   input  logic                       reset,
   rcf_req_if                         req_bus,
   rcf_rsp_if                         rsp_bus,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rcf_pkg::ADDR_W-1:0] paddr,
   input  logic [rcf_pkg::DATA_W-1:0] pwdata,
   input  logic                       pready,
   output int                         outstanding,
   output int                         error_count
);
   import rcf_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clip;
   } filt_result_type;

   // expected response beats, oldest first
   filt_result_type result_q[$];

   // register mirror
   logic [1:0] mode_reg;
   longint     coef_reg;

   // filter state, one set per mode: hp_x and bp_x at sample scale, the rest at state scale
   longint lp_y;
   longint hp_y;
   longint hp_x;
   longint bp_h;
   longint bp_x;
   longint bp_l;
   bit     sat_hit;

   function automatic void clear_filter();
      lp_y = 0;
      hp_y = 0;
      hp_x = 0;
      bp_h = 0;
      bp_x = 0;
      bp_l = 0;
   endfunction

   // clamp to w signed bits, note any clipping for this beat
   function automatic longint clamp(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         sat_hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat_hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // c * v / 2^COEF_W, rounded half up
   function automatic longint coef_mul(longint c, longint v);
      return (c * v + (longint'(1) <<< (COEF_W - 1))) >>> COEF_W;
   endfunction

   // advance the filter by one request beat and return the response it gives
   function automatic filt_result_type filter_step(logic cmd, logic signed [SAMPLE_W-1:0] smp);
      filt_result_type r;
      longint x;
      longint xs;
      longint xp;
      longint b;
      longint a;
      longint y;
      sat_hit = 1'b0;
      x  = longint'(smp);
      xs = x <<< FRAC_W;
      b  = coef_reg;
      a  = (longint'(1) <<< COEF_W) - b;
      if (cmd == CMD_CLEAR) begin
         clear_filter();
         r.sample = '0;
         r.clip   = 1'b0;
         return r;
      end
      case (mode_reg)
         MODE_LP: begin
            lp_y = clamp(lp_y + coef_mul(b, xs - lp_y), STATE_W);
            y = lp_y;
         end
         MODE_HP: begin
            xp = hp_x <<< FRAC_W;
            hp_y = clamp(coef_mul(a, hp_y + xs - xp), STATE_W);
            hp_x = x;
            y = hp_y;
         end
         MODE_BP: begin
            xp = bp_x <<< FRAC_W;
            bp_h = clamp((xs - xp) + coef_mul(a, bp_h), STATE_W);
            bp_x = x;
            bp_l = clamp(bp_l + coef_mul(b, bp_h - bp_l), STATE_W);
            y = bp_l;
         end
         default: begin
            // unused mode: pass the sample straight through
            r.sample = smp;
            r.clip   = 1'b0;
            return r;
         end
      endcase
      y = clamp((y + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W, SAMPLE_W);
      r.sample = y[SAMPLE_W-1:0];
      r.clip   = sat_hit;
      return r;
   endfunction

   function automatic void report_error(string msg);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s", $time, msg);
   endfunction

   always @(posedge clock) begin
      filt_result_type want;
      if (reset) begin
         mode_reg = MODE_RESET;
         coef_reg = longint'(COEF_RESET);
         clear_filter();
         result_q.delete();
         error_count = 0;
         outstanding <= 0;
      end else begin
         // track register writes
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_COEF)
               coef_reg = longint'(pwdata[COEF_W-1:0]);
            else
               mode_reg = pwdata[1:0];
         end

         // compare each response beat with the oldest expectation
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (result_q.size() == 0) begin
               report_error($sformatf("unexpected response sample_out %0d clipped %0b",
                                      rsp_bus.sample_out, rsp_bus.clipped));
            end else begin
               want = result_q.pop_front();
               if (rsp_bus.sample_out !== want.sample)
                  report_error($sformatf("sample_out expected %0d got %0d",
                                         want.sample, rsp_bus.sample_out));
               if (rsp_bus.clipped !== want.clip)
                  report_error($sformatf("clipped expected %0b got %0b (sample_out %0d)",
                                         want.clip, rsp_bus.clipped, want.sample));
            end
         end

         // predict each accepted request beat
         if (req_bus.valid && req_bus.ready)
            result_q.insert(result_q.size(), filter_step(req_bus.cmd, req_bus.sample_in));

         outstanding <= result_q.size();
      end
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import rcf_pkg::*;

   localparam int TOTAL_ITEMS = 1900;
   localparam int IDLE_GUARD  = 60;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   int                outstanding;
   int                error_count;

   int                         gap_max;
   int                         sent;
   logic signed [SAMPLE_W-1:0] last_smp;

   rcf_req_if req_bus();
   rcf_rsp_if rsp_bus();

   one_pole_rc_filter_lp_hp_bp_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   rcf_filter_checker filt_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .outstanding (outstanding),
      .error_count (error_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // hold off one request beat for a random gap, then present it until taken
   task automatic send(input logic cmd, input logic signed [SAMPLE_W-1:0] smp);
      int gap;
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.sample_in <= smp;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   // drop valid and wait until every response has come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   // setup phase, access phase held until pready, then the bus returns to idle
   task automatic write_reg(input logic idx, input logic [DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] mode, input logic [COEF_W-1:0] coef);
      wait_idle();
      write_reg(REG_MODE, {{(DATA_W-2){1'b0}}, mode});
      write_reg(REG_COEF, {{(DATA_W-COEF_W){1'b0}}, coef});
   endtask

   // mix of extremes, small values, repeats and full-range noise
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic [31:0] r;
      int          v;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
         1, 2: begin
            v = int'($urandom_range(0, 511)) - 256;
            return v[SAMPLE_W-1:0];
         end
         3: return last_smp;
         default: begin
            r = $urandom();
            return r[SAMPLE_W-1:0];
         end
      endcase
   endfunction

   // response side: random stall before each beat
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   initial begin
      logic [1:0]                 mode;
      logic [COEF_W-1:0]          coef;
      logic                       cmd;
      logic signed [SAMPLE_W-1:0] smp;
      int                         n;
      logic [31:0]                r;

      gap_max  = 4;
      sent     = 0;
      last_smp = '0;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_FILTER;
      req_bus.sample_in <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: lowpass at half coefficient
      send(CMD_FILTER, SMP_MAX);
      send(CMD_FILTER, SMP_MAX);
      send(CMD_FILTER, SMP_MIN);
      send(CMD_FILTER, SMP_MIN);
      send(CMD_FILTER, 16'sd1);
      send(CMD_CLEAR, 16'sd0);
      send(CMD_FILTER, -16'sd1);

      // highpass, smallest coefficient: full swings drive the state to saturation
      configure(MODE_HP, 16'd1);
      send(CMD_FILTER, SMP_MAX);
      send(CMD_FILTER, SMP_MIN);
      send(CMD_FILTER, SMP_MAX);
      send(CMD_FILTER, SMP_MIN);
      send(CMD_FILTER, 16'sd0);

      // bandpass, largest coefficient, with a clear in the middle
      configure(MODE_BP, 16'hFFFF);
      send(CMD_FILTER, SMP_MIN);
      send(CMD_FILTER, SMP_MAX);
      send(CMD_FILTER, SMP_MIN);
      send(CMD_CLEAR, SMP_MAX);
      send(CMD_FILTER, 16'sd100);

      // unused mode passes samples through
      configure(MODE_PASS, 16'h8000);
      send(CMD_FILTER, SMP_MIN);
      send(CMD_FILTER, SMP_MAX);
      send(CMD_FILTER, 16'sh5555);

      // coefficient zero: lowpass stages hold, highpass factor is one
      configure(MODE_BP, 16'd0);
      send(CMD_FILTER, SMP_MAX);
      send(CMD_FILTER, SMP_MIN);
      configure(MODE_LP, 16'd0);
      send(CMD_FILTER, SMP_MAX);

      // random phases; modes switch without a clear so each resumes its own state
      while (sent < TOTAL_ITEMS) begin
         mode = ($urandom_range(0, 9) == 0) ? MODE_PASS : 2'($urandom_range(0, 2));
         case ($urandom_range(0, 7))
            0: coef = '0;
            1: coef = 16'd1;
            2: coef = 16'hFFFF;
            3: coef = COEF_RESET;
            4: coef = 16'($urandom_range(1, 512));
            default: coef = 16'($urandom_range(1, 65535));
         endcase
         configure(mode, coef);
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
         n = $urandom_range(20, 90);
         repeat (n) begin
            r   = $urandom();
            cmd = ($urandom_range(0, 39) == 0) ? CMD_CLEAR : CMD_FILTER;
            smp = cmd == CMD_CLEAR ? r[SAMPLE_W-1:0] : pick_sample();
            send(cmd, smp);
            last_smp = smp;
         end
      end

      wait_idle();
      if (error_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/rcf_pkg.sv
rtl/rcf_if.sv
rtl/rcf_mul.sv
rtl/one_pole_rc_filter_lp_hp_bp_unit.sv
sim/rcf_filter_checker.sv
sim/testbench.sv
